/* hw/rtl/amls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package amls_pkg;

	localparam int RX_BUF_BYTES = 256;
	localparam int RX_CNT_W = $clog2(RX_BUF_BYTES + 1);
	localparam int NPAT = 12;

	localparam int M_READY = 0;
	localparam int M_OK = 1;
	localparam int M_NOCHG = 2;
	localparam int M_GOTIP = 3;
	localparam int M_FAIL = 4;
	localparam int M_ERROR = 5;
	localparam int M_CONNECT = 6;
	localparam int M_CLOSED = 7;
	localparam int M_DISC = 8;
	localparam int M_IPD = 9;
	localparam int M_SENDOK = 10;
	localparam int M_PROMPT = 11;

	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_CONNECT = 2'd2;
	localparam logic [1:0] CMD_SEND = 2'd3;

	localparam logic [3:0] AT_NONE = 4'd0;
	localparam logic [3:0] AT_RST = 4'd1;
	localparam logic [3:0] AT_ATE0 = 4'd2;
	localparam logic [3:0] AT_AT = 4'd3;
	localparam logic [3:0] AT_CWMODE = 4'd4;
	localparam logic [3:0] AT_CWJAP = 4'd5;
	localparam logic [3:0] AT_CIPSTART = 4'd6;
	localparam logic [3:0] AT_CIPSEND = 4'd7;
	localparam logic [3:0] AT_PAYLOAD = 4'd8;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_CONNECTED = 3'd1;
	localparam logic [2:0] EV_DISCONNECTED = 3'd2;
	localparam logic [2:0] EV_ERROR = 3'd3;
	localparam logic [2:0] EV_DATA = 3'd4;

	localparam logic [3:0] ERR_AT_TMO = 4'd0;
	localparam logic [3:0] ERR_MODE_TMO = 4'd1;
	localparam logic [3:0] ERR_JOIN_FAIL = 4'd2;
	localparam logic [3:0] ERR_JOIN_TMO = 4'd3;
	localparam logic [3:0] ERR_TCP_FAIL = 4'd4;
	localparam logic [3:0] ERR_TCP_TMO = 4'd5;
	localparam logic [3:0] ERR_SEND_ERR = 4'd6;
	localparam logic [3:0] ERR_SEND_TMO = 4'd7;
	localparam logic [3:0] ERR_DONE_ERR = 4'd8;
	localparam logic [3:0] ERR_DONE_TMO = 4'd9;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RESET = 4'd1;
	localparam logic [3:0] ST_INIT = 4'd2;
	localparam logic [3:0] ST_MODE = 4'd3;
	localparam logic [3:0] ST_JOIN = 4'd4;
	localparam logic [3:0] ST_TCP = 4'd5;
	localparam logic [3:0] ST_READY = 4'd6;
	localparam logic [3:0] ST_PROMPT = 4'd7;
	localparam logic [3:0] ST_SENDDONE = 4'd8;
	localparam logic [3:0] ST_ERROR = 4'd9;

	localparam logic [2:0] REG_RESET_WAIT = 3'd0;
	localparam logic [2:0] REG_COMMAND_WAIT = 3'd1;
	localparam logic [2:0] REG_JOIN_WAIT = 3'd2;
	localparam logic [2:0] REG_LINK_WAIT = 3'd3;
	localparam logic [2:0] REG_SEND_DONE_WAIT = 3'd4;

	localparam logic [1:0] FP_HUNT = 2'd0;
	localparam logic [1:0] FP_LEN = 2'd1;
	localparam logic [1:0] FP_PAYLOAD = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
		logic [7:0] send_len;
	} req_t;

	typedef struct packed {
		logic [3:0] at_command;
		logic [7:0] at_length;
		logic [2:0] event_res;
		logic [3:0] error_code;
		logic [7:0] data_byte;
		logic       data_last;
		logic       send_accepted;
		logic [3:0] link_state;
		logic       wifi_up;
		logic       tcp_up;
	} res_t;

	typedef logic [3:0] prog_t [NPAT];

	function automatic logic [3:0] pat_len(input int i);
		case (i)
			0: return 4'd5;
			1: return 4'd2;
			2: return 4'd9;
			3: return 4'd11;
			4: return 4'd4;
			5: return 4'd5;
			6: return 4'd7;
			7: return 4'd6;
			8: return 4'd10;
			9: return 4'd5;
			10: return 4'd7;
			default: return 4'd1;
		endcase
	endfunction

	function automatic logic [7:0] pat_chr(input int i, input int k);
		logic [8*11-1:0] s;
		case (i)
			0: s = {"ready", 48'd0};
			1: s = {"OK", 72'd0};
			2: s = {"no change", 16'd0};
			3: s = "WIFI GOT IP";
			4: s = {"FAIL", 56'd0};
			5: s = {"ERROR", 48'd0};
			6: s = {"CONNECT", 32'd0};
			7: s = {"CLOSED", 40'd0};
			8: s = {"DISCONNECT", 8'd0};
			9: s = {"+IPD,", 48'd0};
			10: s = {"SEND OK", 32'd0};
			default: s = {">", 80'd0};
		endcase
		return s[8*(10-k) +: 8];
	endfunction

	// next progress for pattern i from progress p on byte c (evaluated combinationally by the matcher)
	function automatic logic [3:0] advance(input int i, input logic [3:0] p_in,
			input logic [7:0] c);
		int len;
		int p;
		int k;
		int j;
		logic ok;
		logic [3:0] res;
		len = int'(pat_len(i));
		p = int'(p_in);
		res = 4'd0;
		if (p > len)
			p = 0;
		for (k = 11; k >= 1; k--) begin
			if (k <= len && k <= p + 1 && res == 4'd0) begin
				ok = (pat_chr(i, k - 1) == c);
				for (j = 0; j < 10; j++) begin
					if (j < k - 1 && pat_chr(i, j) != pat_chr(i, p - k + 1 + j))
						ok = 1'b0;
				end
				if (ok)
					res = 4'(k);
			end
		end
		return res;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/at_modem_link_sequencer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// AT modem link sequencer
// req channel (req_valid/req_ready/req): received byte, millisecond tick,
// connect request or send request; each request produces exactly one result
// on the res channel (res_valid/res_ready/res).
// The request is evaluated in the cycle it is accepted: matchers, timeout
// and sequence state are updated together and the result lands in the
// output register; one request per cycle is taken while the result
// register is empty or being drained.
// When the receiver stalls the result is held and req_ready drops until it
// is taken; no request is lost.
// cfg_we/cfg_index/cfg_wdata write the five timeout registers in ms.
// Reset (arst_n low) returns to idle with empty buffer, cleared flags and
// default timeouts; no clearing pass is needed.
module at_modem_link_sequencer_top
	import amls_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire req_t        req,
	output logic             res_valid,
	input  wire logic        res_ready,
	output res_t             res,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	logic [15:0] reset_wait_q, command_wait_q, join_wait_q, link_wait_q, send_done_wait_q;
	logic [3:0] state_q;
	logic [RX_CNT_W-1:0] rx_count_q;
	logic [15:0] elapsed_q, limit_q;
	logic [7:0] pending_q, flen_q;
	logic [1:0] fphase_q;
	logic wifi_q, tcp_q;

	logic go;
	logic feed, flush;
	logic [NPAT-1:0] seen_q, seen_n;
	res_t r;
	logic [3:0] st_n;
	logic [RX_CNT_W-1:0] cnt_n;
	logic [15:0] el_n, lim_n;
	logic [7:0] pend_n, flen_n;
	logic [1:0] fph_n;
	logic wifi_n, tcp_n;

	assign req_ready = !res_valid || res_ready;
	assign go = req_valid && req_ready;

	amls_matcher u_match (
		.clk(clk), .arst_n(arst_n), .feed(go && feed), .flush(go && flush),
		.rx_byte(req.rx_byte), .seen_q(seen_q), .seen_next(seen_n)
	);

	always_comb begin
		logic [NPAT-1:0] sn;
		logic fl;
		logic ev;
		logic expd;
		r = '0;
		st_n = state_q;
		cnt_n = rx_count_q;
		el_n = elapsed_q;
		lim_n = limit_q;
		pend_n = pending_q;
		flen_n = flen_q;
		fph_n = fphase_q;
		wifi_n = wifi_q;
		tcp_n = tcp_q;
		feed = 1'b0;
		fl = 1'b0;
		ev = 1'b0;
		sn = seen_q;
		case (req.command)
			CMD_CONNECT: begin
				wifi_n = 1'b0;
				tcp_n = 1'b0;
				fl = 1'b1;
				r.at_command = AT_RST;
				st_n = ST_RESET;
				el_n = '0;
				lim_n = reset_wait_q;
			end
			CMD_SEND: begin
				if (state_q == ST_READY && req.send_len != 8'd0) begin
					pend_n = req.send_len;
					r.at_length = req.send_len;
					r.send_accepted = 1'b1;
					fl = 1'b1;
					r.at_command = AT_CIPSEND;
					st_n = ST_PROMPT;
					el_n = '0;
					lim_n = command_wait_q;
				end
			end
			CMD_TICK: begin
				if (elapsed_q != 16'hFFFF)
					el_n = elapsed_q + 16'd1;
				ev = 1'b1;
			end
			default: begin
				if (state_q == ST_READY && fphase_q == FP_PAYLOAD) begin
					r.event_res = EV_DATA;
					r.data_byte = req.rx_byte;
					flen_n = flen_q - 8'd1;
					if (flen_n == 8'd0) begin
						r.data_last = 1'b1;
						fl = 1'b1;
					end
				end else begin
					if (rx_count_q < RX_CNT_W'(RX_BUF_BYTES)) begin
						cnt_n = rx_count_q + RX_CNT_W'(1);
						feed = 1'b1;
						sn = seen_n;
						if (state_q == ST_READY && fphase_q == FP_LEN) begin
							if (req.rx_byte == 8'h3A) begin
								if (flen_q == 8'd0)
									fl = 1'b1;
								else
									fph_n = FP_PAYLOAD;
							end else begin
								flen_n = 8'((flen_q * 10) + req.rx_byte - 8'd48);
							end
						end
					end
					ev = 1'b1;
				end
			end
		endcase
		// a flush from the byte, connect or send path resets the parse before evaluation
		if (fl) begin
			cnt_n = '0;
			fph_n = FP_HUNT;
			flen_n = '0;
			sn = '0;
		end
		expd = el_n >= lim_n;
		if (ev) begin
			unique case (state_q)
				ST_IDLE, ST_ERROR: ;
				ST_RESET: begin
					if (sn[M_READY] || expd) begin
						fl = 1'b1;
						r.at_command = sn[M_READY] ? AT_ATE0 : AT_AT;
						st_n = ST_INIT;
						el_n = '0;
						lim_n = command_wait_q;
					end
				end
				ST_INIT: begin
					if (sn[M_OK]) begin
						fl = 1'b1;
						r.at_command = AT_CWMODE;
						st_n = ST_MODE;
						el_n = '0;
						lim_n = command_wait_q;
					end else if (expd) begin
						st_n = ST_ERROR; tcp_n = 1'b0;
						r.event_res = EV_ERROR; r.error_code = ERR_AT_TMO;
					end
				end
				ST_MODE: begin
					if (sn[M_OK] || sn[M_NOCHG]) begin
						fl = 1'b1;
						r.at_command = AT_CWJAP;
						st_n = ST_JOIN;
						el_n = '0;
						lim_n = join_wait_q;
					end else if (expd) begin
						st_n = ST_ERROR; tcp_n = 1'b0;
						r.event_res = EV_ERROR; r.error_code = ERR_MODE_TMO;
					end
				end
				ST_JOIN: begin
					if (sn[M_GOTIP] || sn[M_OK]) begin
						wifi_n = 1'b1;
						fl = 1'b1;
						r.at_command = AT_CIPSTART;
						st_n = ST_TCP;
						el_n = '0;
						lim_n = link_wait_q;
					end else if (sn[M_FAIL] || sn[M_ERROR]) begin
						st_n = ST_ERROR; tcp_n = 1'b0;
						r.event_res = EV_ERROR; r.error_code = ERR_JOIN_FAIL;
					end else if (expd) begin
						st_n = ST_ERROR; tcp_n = 1'b0;
						r.event_res = EV_ERROR; r.error_code = ERR_JOIN_TMO;
					end
				end
				ST_TCP: begin
					if (sn[M_CONNECT]) begin
						tcp_n = 1'b1;
						fl = 1'b1;
						st_n = ST_READY;
						r.event_res = EV_CONNECTED;
					end else if (sn[M_ERROR] || sn[M_CLOSED]) begin
						st_n = ST_ERROR; tcp_n = 1'b0;
						r.event_res = EV_ERROR; r.error_code = ERR_TCP_FAIL;
					end else if (expd) begin
						st_n = ST_ERROR; tcp_n = 1'b0;
						r.event_res = EV_ERROR; r.error_code = ERR_TCP_TMO;
					end
				end
				ST_READY: begin
					if (sn[M_CLOSED] || sn[M_DISC]) begin
						tcp_n = 1'b0;
						r.event_res = EV_DISCONNECTED;
						fl = 1'b1;
						r.at_command = AT_CIPSTART;
						st_n = ST_TCP;
						el_n = '0;
						lim_n = link_wait_q;
					end else if (fph_n == FP_HUNT && sn[M_IPD]) begin
						fph_n = FP_LEN;
						flen_n = '0;
					end
				end
				ST_PROMPT: begin
					if (sn[M_PROMPT]) begin
						fl = 1'b1;
						r.at_command = AT_PAYLOAD;
						st_n = ST_SENDDONE;
						el_n = '0;
						lim_n = send_done_wait_q;
						r.at_length = pending_q;
					end else if (sn[M_ERROR]) begin
						st_n = ST_ERROR; tcp_n = 1'b0;
						r.event_res = EV_ERROR; r.error_code = ERR_SEND_ERR;
					end else if (expd) begin
						st_n = ST_ERROR; tcp_n = 1'b0;
						r.event_res = EV_ERROR; r.error_code = ERR_SEND_TMO;
					end
				end
				ST_SENDDONE: begin
					if (sn[M_SENDOK]) begin
						fl = 1'b1;
						pend_n = '0;
						st_n = ST_READY;
					end else if (sn[M_ERROR]) begin
						st_n = ST_ERROR; tcp_n = 1'b0;
						r.event_res = EV_ERROR; r.error_code = ERR_DONE_ERR;
					end else if (expd) begin
						st_n = ST_ERROR; tcp_n = 1'b0;
						r.event_res = EV_ERROR; r.error_code = ERR_DONE_TMO;
					end
				end
				default: st_n = ST_IDLE;
			endcase
		end
		if (fl) begin
			cnt_n = '0;
			fph_n = FP_HUNT;
			flen_n = '0;
		end
		flush = fl;
		r.link_state = st_n;
		r.wifi_up = wifi_n;
		r.tcp_up = tcp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_wait_q <= 16'd3000;
			command_wait_q <= 16'd2000;
			join_wait_q <= 16'd15000;
			link_wait_q <= 16'd10000;
			send_done_wait_q <= 16'd3000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESET_WAIT: reset_wait_q <= cfg_wdata;
				REG_COMMAND_WAIT: command_wait_q <= cfg_wdata;
				REG_JOIN_WAIT: join_wait_q <= cfg_wdata;
				REG_LINK_WAIT: link_wait_q <= cfg_wdata;
				REG_SEND_DONE_WAIT: send_done_wait_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rx_count_q <= '0;
			elapsed_q <= '0;
			limit_q <= '0;
			pending_q <= '0;
			fphase_q <= FP_HUNT;
			flen_q <= '0;
			wifi_q <= 1'b0;
			tcp_q <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (go) begin
				state_q <= st_n;
				rx_count_q <= cnt_n;
				elapsed_q <= el_n;
				limit_q <= lim_n;
				pending_q <= pend_n;
				fphase_q <= fph_n;
				flen_q <= flen_n;
				wifi_q <= wifi_n;
				tcp_q <= tcp_n;
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go)
			res <= r;
	end

	assert property (@(posedge clk) disable iff (!arst_n) go |=> res_valid)
		else $error("result missing after request");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |-> !req_ready)
		else $error("request taken while result stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= RX_CNT_W'(RX_BUF_BYTES))
		else $error("receive count beyond buffer");
	assert property (@(posedge clk) disable iff (!arst_n)
		(tcp_q && !(state_q == ST_IDLE || state_q == ST_ERROR)) |-> wifi_q)
		else $error("tcp up without wifi");

endmodule
`default_nettype wire

/* hw/rtl/amls_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none
module amls_matcher
	import amls_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            feed,
	input  wire logic            flush,
	input  wire logic [7:0]      rx_byte,
	output logic [NPAT-1:0]      seen_q,
	output logic [NPAT-1:0]      seen_next
);

	prog_t prog_q;
	prog_t prog_next;

	always_comb begin
		for (int i = 0; i < NPAT; i++) begin
			prog_next[i] = advance(i, prog_q[i], rx_byte);
			seen_next[i] = seen_q[i] | (feed && prog_next[i] == pat_len(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < NPAT; i++)
				prog_q[i] <= 4'd0;
		end else if (flush) begin
			seen_q <= '0;
			for (int i = 0; i < NPAT; i++)
				prog_q[i] <= 4'd0;
		end else if (feed) begin
			seen_q <= seen_next;
			prog_q <= prog_next;
		end
	end

endmodule
`default_nettype wire
